>>> rtl/core/lbvs_pkg.sv
// shared widths and types for the four-bone vertex skinning unit
// no dependencies
package lbvs_pkg;

  localparam int unsigned WordsPerBone = 12;
  localparam int unsigned Slots        = 4;
  localparam int unsigned WordW        = 4;
  localparam int unsigned ProdW        = 48;
  localparam int unsigned TermW        = 50;
  localparam int unsigned ContribW     = 52;
  localparam int unsigned SumW         = 54;

  // reciprocal of twelve for a ten-bit address, exact over the address range
  localparam logic [11:0] RecipTwelve = 12'd2731;

  localparam logic KindLoad = 1'b0;
  localparam logic KindSkin = 1'b1;

  // palette word write request shared by all bone slots
  typedef struct packed {
    logic             en;
    logic [WordW-1:0] word;
  } pal_wr_t;

  typedef logic signed [ContribW-1:0] contrib_t;

endpackage

>>> rtl/core/lbvs_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module lbvs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/core/lbvs_bone.sv
// one bone slot: twelve palette word memories, matrix product and weighting
// depends on lbvs_pkg and lbvs_ram
module lbvs_bone import lbvs_pkg::*; #(
  parameter int unsigned NumBones = 64,
  parameter int unsigned BoneW    = 6
) (
  input  logic                     clk_i,
  input  logic                     adv_i,
  input  pal_wr_t                  wr_i,
  input  logic [BoneW-1:0]         wr_addr_i,
  input  logic [31:0]              wr_data_i,
  input  logic [BoneW-1:0]         rd_addr_i,
  input  logic                     use_i,
  input  logic [15:0]              weight_i,
  input  logic signed [31:0]       pos_i [3],
  output contrib_t                 contrib_o [3]
);

  logic [31:0]             rdata [WordsPerBone];
  logic signed [ProdW-1:0] prod_d [3][3];
  logic signed [ProdW-1:0] prod_q [3][3];
  logic signed [31:0]      trans_q [3];
  logic signed [TermW-1:0] term_d [3];
  logic signed [TermW-1:0] term_q [3];
  contrib_t                contrib_d [3];
  contrib_t                contrib_q [3];
  logic                    use1_q, use2_q, use3_q;
  logic [15:0]             w1_q, w2_q, w3_q;

  // one memory per matrix word, all indexed by bone
  for (genvar j = 0; j < WordsPerBone; j++) begin : g_word
    lbvs_ram #(.Width(32), .Depth(NumBones)) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_i.en && (wr_i.word == WordW'(j))),
      .waddr_i (wr_addr_i),
      .wdata_i (wr_data_i),
      .re_i    (adv_i),
      .raddr_i (rd_addr_i),
      .rdata_o (rdata[j])
    );
  end

  // matrix times position, each product floored
  always_comb begin
    logic signed [63:0] p;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p = $signed(rdata[r*4+c]) * pos_i[c];
        prod_d[r][c] = p[63:16];
      end
    end
  end

  // row sums plus translation
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      term_d[r] = TermW'(prod_q[r][0]) + TermW'(prod_q[r][1]) + TermW'(prod_q[r][2])
                + TermW'(trans_q[r]);
    end
  end

  // weighting, floored; unused bones give zero
  always_comb begin
    logic signed [66:0] tw;
    for (int r = 0; r < 3; r++) begin
      tw = term_q[r] * $signed({1'b0, w3_q});
      contrib_d[r] = use3_q ? $signed(tw[66:15]) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      use1_q <= use_i;
      w1_q   <= weight_i;
      use2_q <= use1_q;
      w2_q   <= w1_q;
      use3_q <= use2_q;
      w3_q   <= w2_q;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= prod_d[r][c];
        end
        trans_q[r]   <= $signed(rdata[r*4+3]);
        term_q[r]    <= term_d[r];
        contrib_q[r] <= contrib_d[r];
      end
    end
  end

  assign contrib_o = contrib_q;

endmodule

>>> rtl/core/linear_blend_vertex_skinning_unit.sv
// four-bone linear blend skinning unit with a loadable bone palette
// five register stages: palette read, matrix products, row sums, weighting, blended result
// throughput one item per cycle while the output is not stalled, loads give no result
// the whole pipeline moves together and stalls only while a result waits
// reset clears control and sets skinning enabled; palette contents stay undefined
// depends on lbvs_pkg, lbvs_bone and lbvs_ram
module linear_blend_vertex_skinning_unit import lbvs_pkg::*; #(
  parameter int unsigned NUM_BONES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [63:0]        weights_packed_i,
  input  logic [31:0]        bones_packed_i,
  input  logic [9:0]         load_address_i,
  input  logic signed [31:0] load_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o
);

  localparam int unsigned BoneW = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;

  logic               adv, acc;
  logic               skin_en_q;
  logic [3:0]         vld_q;
  logic [3:0]         en_q;
  logic signed [31:0] pos_q [4][3];
  logic signed [31:0] pos_in [3];
  logic [21:0]        div_prod;
  logic [6:0]         quot;
  logic [9:0]         rem;
  logic               ld_ok;
  pal_wr_t            wr;
  contrib_t           contrib [Slots][3];
  logic signed [31:0] res_d [3];
  logic signed [31:0] res_q [3];

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign acc        = in_valid_i && adv;

  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;

  // split palette address into bone and word
  assign div_prod = 22'(load_address_i) * 22'(RecipTwelve);
  assign quot     = div_prod[21:15];
  assign rem      = load_address_i - 10'(quot) * 10'd12;
  assign ld_ok    = {2'b0, load_address_i} < 12'(NUM_BONES * WordsPerBone);
  assign wr.en    = acc && (kind_i == KindLoad) && ld_ok;
  assign wr.word  = rem[WordW-1:0];

  for (genvar k = 0; k < Slots; k++) begin : g_slot
    logic [7:0]  bone;
    logic [15:0] wt;
    assign bone = bones_packed_i[8*k +: 8];
    assign wt   = weights_packed_i[16*k +: 16];
    lbvs_bone #(.NumBones(NUM_BONES), .BoneW(BoneW)) u_bone (
      .clk_i     (clk_i),
      .adv_i     (adv),
      .wr_i      (wr),
      .wr_addr_i (BoneW'(quot)),
      .wr_data_i (load_value_i),
      .rd_addr_i (BoneW'(bone)),
      .use_i     ((wt != 16'd0) && ({1'b0, bone} < 9'(NUM_BONES))),
      .weight_i  (wt),
      .pos_i     (pos_q[0]),
      .contrib_o (contrib[k])
    );
  end

  // blend sum and saturation, or pass-through
  always_comb begin
    logic signed [SumW-1:0] s;
    for (int r = 0; r < 3; r++) begin
      s = SumW'(contrib[0][r]) + SumW'(contrib[1][r]) + SumW'(contrib[2][r])
        + SumW'(contrib[3][r]);
      if (!en_q[3]) begin
        res_d[r] = pos_q[3][r];
      end else if (s > SumW'(64'sh7FFFFFFF)) begin
        res_d[r] = 32'sh7FFFFFFF;
      end else if (s < -SumW'(64'sh80000000)) begin
        res_d[r] = -32'sh80000000;
      end else begin
        res_d[r] = s[31:0];
      end
    end
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skin_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      skin_en_q <= cfg_wdata_i;
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[2:0], acc && (kind_i == KindSkin)};
      out_valid_o <= vld_q[3];
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      en_q     <= {en_q[2:0], skin_en_q};
      pos_q[0] <= pos_in;
      pos_q[1] <= pos_q[0];
      pos_q[2] <= pos_q[1];
      pos_q[3] <= pos_q[2];
      res_q    <= res_d;
    end
  end

  assign out_x_o = res_q[0];
  assign out_y_o = res_q[1];
  assign out_z_o = res_q[2];

endmodule
